// ----- rtl/cnms_pkg.sv -----
`timescale 1ns / 1ps
package cnms_pkg;

	localparam int MAG_BITS  = 16;
	localparam int GRAD_BITS = 16;
	localparam int DEF_MAX_WIDTH = 2048;
	localparam int ROW_BITS  = 16;
	localparam int COL_BITS  = 11;
	localparam int EDGE_BITS = 16;
	localparam int THR_BITS  = 16;
	localparam int IW_BITS   = 12;
	localparam int IH_BITS   = 16;
	localparam int CFG_BITS  = 16;
	localparam int QUEUE_DEPTH = 4;

	// register indexes of the configuration port
	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_WIDTH     = 2'd1;
	localparam logic [1:0] REG_HEIGHT    = 2'd2;

	typedef struct packed {
		logic [MAG_BITS-1:0]         magnitude;
		logic signed [GRAD_BITS-1:0] grad_y;
		logic signed [GRAD_BITS-1:0] grad_x;
		logic                        mask_enable;
	} in_t;

	typedef struct packed {
		logic [EDGE_BITS-1:0] edge_value;
		logic [ROW_BITS-1:0]  center_row;
		logic [COL_BITS-1:0]  center_column;
		logic                 frame_last;
	} out_t;

	typedef struct packed {
		logic [THR_BITS-1:0] threshold;
		logic [IW_BITS-1:0]  width;
		logic [IH_BITS-1:0]  height;
	} cfg_t;

	// classified centre pixel handed from front to back
	typedef struct packed {
		logic                 zero;
		logic [MAG_BITS-1:0]  mag;
		logic [GRAD_BITS-1:0] num;
		logic [GRAD_BITS-1:0] den;
		logic [MAG_BITS-1:0]  p1a;
		logic [MAG_BITS-1:0]  p2a;
		logic [MAG_BITS-1:0]  p1b;
		logic [MAG_BITS-1:0]  p2b;
		logic [ROW_BITS-1:0]  row;
		logic [COL_BITS-1:0]  col;
		logic                 last;
	} cls_t;

endpackage

// ----- rtl/cnms_front.sv -----
`timescale 1ns / 1ps
module cnms_front import cnms_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	input  cfg_t cfg,
	input  logic q_full,
	output logic push,
	output cls_t push_data
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	typedef struct packed {
		logic [GRAD_BITS-1:0] gy;
		logic [GRAD_BITS-1:0] gx;
		logic                 en;
	} grad_t;

	typedef struct packed {
		logic [MAG_BITS-1:0] above;
		logic [MAG_BITS-1:0] two;
		grad_t               grad;
	} line_t;

	line_t mem_q [MAX_WIDTH];
	line_t rd_q;

	logic [AW-1:0]       col_q;
	logic [ROW_BITS-1:0] row_q;
	logic [15:0]         w_eff, w_last, h_last;

	logic                v_s1, emit_s1, last_s1;
	logic [MAG_BITS-1:0] mag_s1;
	grad_t               grad_s1;
	logic [AW-1:0]       addr_s1;
	logic [ROW_BITS-1:0] row_s1;
	logic [COL_BITS-1:0] col_s1;

	logic [MAG_BITS-1:0] win_q [9];
	logic [MAG_BITS-1:0] win_n [9];
	grad_t               hold_q;

	logic en_f, accept, fire;
	logic ny, nx, same;
	logic [GRAD_BITS-1:0] ay, ax;

	// clamp frame size
	always_comb begin
		if (cfg.width < IW_BITS'(3))
			w_eff = 16'd3;
		else if (16'(cfg.width) > 16'(MAX_WIDTH))
			w_eff = 16'(MAX_WIDTH);
		else
			w_eff = 16'(cfg.width);
		w_last = w_eff - 16'd1;
		h_last = (cfg.height < IH_BITS'(3)) ? 16'd2 : 16'(cfg.height - IH_BITS'(1));
	end

	assign en_f     = !v_s1 || !emit_s1 || !q_full;
	assign in_ready = en_f;
	assign accept   = in_valid && en_f;
	assign fire     = v_s1 && en_f;

	// advance raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (16'(col_q) >= w_last) begin
				col_q <= '0;
				row_q <= (16'(row_q) >= h_last) ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// stage one valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (en_f)
			v_s1 <= in_valid;
	end

	// stage one payload and line read
	always_ff @(posedge clk) begin
		if (accept) begin
			mag_s1   <= in_data.magnitude;
			grad_s1  <= '{gy: in_data.grad_y, gx: in_data.grad_x, en: in_data.mask_enable};
			addr_s1  <= col_q;
			emit_s1  <= (row_q >= ROW_BITS'(2)) && (col_q >= AW'(2));
			row_s1   <= row_q - 1'b1;
			col_s1   <= COL_BITS'(col_q - 1'b1);
			last_s1  <= (16'(row_q) == h_last) && (16'(col_q) == w_last);
			rd_q     <= mem_q[col_q];
		end
	end

	// write back the line entry as the pixel leaves stage one
	always_ff @(posedge clk) begin
		if (fire)
			mem_q[addr_s1] <= '{above: mag_s1, two: rd_q.above, grad: grad_s1};
	end

	// shift the window
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			win_n[k*3]     = win_q[k*3+1];
			win_n[k*3+1]   = win_q[k*3+2];
		end
		win_n[2] = rd_q.two;
		win_n[5] = rd_q.above;
		win_n[8] = mag_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 9; k++)
				win_q[k] <= '0;
			hold_q <= '0;
		end else if (fire) begin
			for (int k = 0; k < 9; k++)
				win_q[k] <= win_n[k];
			hold_q <= rd_q.grad;
		end
	end

	// classify the centre pixel
	always_comb begin
		ny   = hold_q.gy[GRAD_BITS-1];
		nx   = hold_q.gx[GRAD_BITS-1];
		ay   = ny ? (~hold_q.gy + 1'b1) : hold_q.gy;
		ax   = nx ? (~hold_q.gx + 1'b1) : hold_q.gx;
		same = (ay == '0) || (ax == '0) || (ny == nx);
		push_data      = '0;
		push_data.mag  = win_n[4];
		push_data.zero = !hold_q.en || (33'(win_n[4]) < 33'(cfg.threshold))
			|| ((ay == '0) && (ax == '0));
		push_data.row  = row_s1;
		push_data.col  = col_s1;
		push_data.last = last_s1;
		if (same) begin
			if (ay > ax) begin
				push_data.num = ax; push_data.den = ay;
				push_data.p1a = win_n[7]; push_data.p2a = win_n[8];
				push_data.p1b = win_n[1]; push_data.p2b = win_n[0];
			end else begin
				push_data.num = ay; push_data.den = ax;
				push_data.p1a = win_n[5]; push_data.p2a = win_n[8];
				push_data.p1b = win_n[3]; push_data.p2b = win_n[0];
			end
		end else begin
			if (ay < ax) begin
				push_data.num = ay; push_data.den = ax;
				push_data.p1a = win_n[5]; push_data.p2a = win_n[2];
				push_data.p1b = win_n[3]; push_data.p2b = win_n[6];
			end else begin
				push_data.num = ax; push_data.den = ay;
				push_data.p1a = win_n[1]; push_data.p2a = win_n[2];
				push_data.p1b = win_n[7]; push_data.p2b = win_n[6];
			end
		end
	end

	assign push = fire && emit_s1;

endmodule

// ----- rtl/cnms_queue.sv -----
`timescale 1ns / 1ps
module cnms_queue import cnms_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cls_t push_data,
	output logic full,
	input  logic pop,
	output logic empty,
	output cls_t pop_data
);

	localparam int QW = $clog2(QUEUE_DEPTH);

	cls_t          buf_q [QUEUE_DEPTH];
	logic [QW-1:0] wr_q, rd_q;
	logic [QW:0]   cnt_q;

	assign full     = (cnt_q == (QW+1)'(QUEUE_DEPTH));
	assign empty    = (cnt_q == '0);
	assign pop_data = buf_q[rd_q];

	// hold entries
	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_q] <= push_data;
	end

	// advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QW+1)'(push) - (QW+1)'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("beat pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("beat popped from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QW+1)'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

// ----- rtl/cnms_back.sv -----
`timescale 1ns / 1ps
module cnms_back import cnms_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic empty,
	output logic pop,
	input  cls_t pop_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	localparam int PW = MAG_BITS + GRAD_BITS;

	logic                 adv;
	logic                 v_b1, v_b2;
	cls_t                 e_b1;
	logic [GRAD_BITS-1:0] dn_b1;
	logic [PW-1:0]        a1_b2, a2_b2, b1_b2, b2_b2, pm_b2;
	logic                 zero_b2, last_b2;
	logic [MAG_BITS-1:0]  mag_b2;
	logic [ROW_BITS-1:0]  row_b2;
	logic [COL_BITS-1:0]  col_b2;
	logic                 keep;

	assign adv = !out_valid || out_ready;
	assign pop = adv && !empty;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1      <= 1'b0;
			v_b2      <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v_b1      <= !empty;
			v_b2      <= v_b1;
			out_valid <= v_b2;
		end
	end

	// take entry, form den - num
	always_ff @(posedge clk) begin
		if (pop) begin
			e_b1  <= pop_data;
			dn_b1 <= pop_data.den - pop_data.num;
		end
	end

	// multiply
	always_ff @(posedge clk) begin
		if (adv) begin
			a2_b2   <= PW'(e_b1.p2a) * PW'(e_b1.num);
			a1_b2   <= PW'(e_b1.p1a) * PW'(dn_b1);
			b2_b2   <= PW'(e_b1.p2b) * PW'(e_b1.num);
			b1_b2   <= PW'(e_b1.p1b) * PW'(dn_b1);
			pm_b2   <= PW'(e_b1.mag) * PW'(e_b1.den);
			zero_b2 <= e_b1.zero;
			mag_b2  <= e_b1.mag;
			row_b2  <= e_b1.row;
			col_b2  <= e_b1.col;
			last_b2 <= e_b1.last;
		end
	end

	// compare both interpolations against the centre
	assign keep = !zero_b2
		&& ((PW+1)'(a2_b2) + (PW+1)'(a1_b2) <= (PW+1)'(pm_b2))
		&& ((PW+1)'(b2_b2) + (PW+1)'(b1_b2) <= (PW+1)'(pm_b2));

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data.edge_value    <= keep ? EDGE_BITS'(mag_b2) : '0;
			out_data.center_row    <= row_b2;
			out_data.center_column <= col_b2;
			out_data.frame_last    <= last_b2;
		end
	end

endmodule

// ----- rtl/canny_nonmax_suppression_unit.sv -----
`timescale 1ns / 1ps
// A result follows the beat of the pixel one row and one column past its centre, through
// stage one, the queue, the b1 and b2 stages and the output register.
// Throughput: one pixel per cycle while the queue is not full; one line store read and one write per pixel set it.
// A 4-entry queue parts the classify front from the multiply/compare back.
// Reset: counters, window, queue, valids and config go to reset values at once.
// The line store is not cleared; its entries are valid once the first rows are written.
module canny_nonmax_suppression_unit import cnms_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_t                 in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output out_t                out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data
);

	cfg_t cfg_q;
	logic push, full, pop, empty;
	cls_t push_data, pop_data;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold <= '0;
			cfg_q.width     <= IW_BITS'(2048);
			cfg_q.height    <= IH_BITS'(65535);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_THRESHOLD: cfg_q.threshold <= THR_BITS'(cfg_data);
				REG_WIDTH:     cfg_q.width     <= IW_BITS'(cfg_data);
				REG_HEIGHT:    cfg_q.height    <= IH_BITS'(cfg_data);
				default:       ;
			endcase
		end
	end

	cnms_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.cfg(cfg_q), .q_full(full), .push(push), .push_data(push_data)
	);

	cnms_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_data(push_data), .full(full),
		.pop(pop), .empty(empty), .pop_data(pop_data)
	);

	cnms_back u_back (
		.clk(clk), .arst_n(arst_n),
		.empty(empty), .pop(pop), .pop_data(pop_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

endmodule

// ----- bench/nms_edge_checker.sv -----
`timescale 1ns / 1ps
module nms_edge_checker import cnms_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  in_t                 in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  out_t                out_data,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data,
	output int                  errors,
	output int                  pending,
	output int                  results_seen,
	output int                  edges_kept
);

	typedef struct packed {
		logic signed [GRAD_BITS-1:0] gy;
		logic signed [GRAD_BITS-1:0] gx;
		logic                        en;
	} grad_rec_t;

	logic [THR_BITS-1:0] thr_reg;
	logic [IW_BITS-1:0]  width_reg;
	logic [IH_BITS-1:0]  height_reg;

	logic [MAG_BITS-1:0] mag_row1 [DEF_MAX_WIDTH];
	logic [MAG_BITS-1:0] mag_row2 [DEF_MAX_WIDTH];
	grad_rec_t           grad_row1 [DEF_MAX_WIDTH];
	logic [MAG_BITS-1:0] win [9];
	grad_rec_t           centre_grad;
	int                  col, row;
	out_t                edge_queue [$];

	assign pending = edge_queue.size();

	// one side of the interpolated comparison
	function automatic bit side_ok(int p1, int p2, longint num, longint den);
		return longint'(p2) * num + longint'(p1) * (den - num) <= longint'(win[4]) * den;
	endfunction

	// suppress or keep the centre of the current window
	function automatic logic [EDGE_BITS-1:0] nms_value(grad_rec_t g);
		int iy, ix, a1, a2, b1, b2;
		longint ay, ax, num, den;
		iy = g.gy;
		ix = g.gx;
		ay = iy < 0 ? -iy : iy;
		ax = ix < 0 ? -ix : ix;
		if (!g.en || win[4] < thr_reg || (ay == 0 && ax == 0))
			return '0;
		if (ay == 0 || ax == 0 || ((iy < 0) == (ix < 0))) begin
			if (ay > ax) begin
				num = ax; den = ay; a1 = 7; a2 = 8; b1 = 1; b2 = 0;
			end else begin
				num = ay; den = ax; a1 = 5; a2 = 8; b1 = 3; b2 = 0;
			end
		end else begin
			if (ay < ax) begin
				num = ay; den = ax; a1 = 5; a2 = 2; b1 = 3; b2 = 6;
			end else begin
				num = ax; den = ay; a1 = 1; a2 = 2; b1 = 7; b2 = 6;
			end
		end
		if (side_ok(win[a1], win[a2], num, den) && side_ok(win[b1], win[b2], num, den))
			return win[4];
		return '0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		int w, h;
		out_t exp_beat;
		grad_rec_t cur;
		if (!arst_n) begin
			thr_reg    <= '0;
			width_reg  <= 12'd2048;
			height_reg <= 16'd65535;
			col = 0;
			row = 0;
			centre_grad = '0;
			for (int k = 0; k < 9; k++) win[k] = '0;
			edge_queue.delete();
			errors = 0;
			results_seen = 0;
			edges_kept = 0;
		end else begin
			// track register writes
			if (cfg_we) begin
				case (cfg_index)
					REG_THRESHOLD: thr_reg    <= cfg_data[THR_BITS-1:0];
					REG_WIDTH:     width_reg  <= cfg_data[IW_BITS-1:0];
					REG_HEIGHT:    height_reg <= cfg_data[IH_BITS-1:0];
					default: ;
				endcase
			end
			// advance the window on each accepted pixel beat
			if (in_valid && in_ready) begin
				w = width_reg < 3 ? 3 : (width_reg > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : width_reg);
				h = height_reg < 3 ? 3 : height_reg;
				cur = '{gy: in_data.grad_y, gx: in_data.grad_x, en: in_data.mask_enable};
				for (int k = 0; k < 3; k++) begin
					win[k*3]   = win[k*3+1];
					win[k*3+1] = win[k*3+2];
				end
				win[2] = mag_row2[col];
				win[5] = mag_row1[col];
				win[8] = in_data.magnitude;
				if (row >= 2 && col >= 2) begin
					exp_beat.edge_value    = nms_value(centre_grad);
					exp_beat.center_row    = ROW_BITS'(row - 1);
					exp_beat.center_column = COL_BITS'(col - 1);
					exp_beat.frame_last    = (row == h - 1 && col == w - 1);
					edge_queue.push_back(exp_beat);
				end
				centre_grad     = grad_row1[col];
				grad_row1[col]  = cur;
				mag_row2[col]   = mag_row1[col];
				mag_row1[col]   = in_data.magnitude;
				if (col >= w - 1) begin
					col = 0;
					row = row >= h - 1 ? 0 : row + 1;
				end else begin
					col = col + 1;
				end
			end
			// compare each result beat with the oldest prediction
			if (out_valid && out_ready) begin
				results_seen++;
				if (out_data.edge_value != 0) edges_kept++;
				if (edge_queue.size() == 0) begin
					$error("unexpected result beat %p", out_data);
					errors++;
				end else begin
					exp_beat = edge_queue.pop_front();
					if (out_data.edge_value !== exp_beat.edge_value) begin
						$error("edge_value: expected %0d, got %0d",
							exp_beat.edge_value, out_data.edge_value);
						errors++;
					end
					if (out_data.center_row !== exp_beat.center_row) begin
						$error("center_row: expected %0d, got %0d",
							exp_beat.center_row, out_data.center_row);
						errors++;
					end
					if (out_data.center_column !== exp_beat.center_column) begin
						$error("center_column: expected %0d, got %0d",
							exp_beat.center_column, out_data.center_column);
						errors++;
					end
					if (out_data.frame_last !== exp_beat.frame_last) begin
						$error("frame_last: expected %0d, got %0d",
							exp_beat.frame_last, out_data.frame_last);
						errors++;
					end
				end
			end
		end
	end

endmodule

// ----- bench/canny_nonmax_suppression_unit_test.sv -----
`timescale 1ns / 1ps
module canny_nonmax_suppression_unit_test;
	import cnms_pkg::*;

	localparam int STALL_LIMIT = 5000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	in_t                 in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	out_t                out_data;
	logic                cfg_we = 1'b0;
	logic [1:0]          cfg_index = REG_THRESHOLD;
	logic [CFG_BITS-1:0] cfg_data = '0;

	int  errors, pending, results_seen, edges_kept;
	int  tx_idle = 30, rx_idle = 68;
	bit  hold_rx = 1'b0;
	int  pixels_sent = 0, frames_sent = 0, quiet_cycles = 0;

	always #4 clk = ~clk;

	canny_nonmax_suppression_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	nms_edge_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(errors), .pending(pending),
		.results_seen(results_seen), .edges_kept(edges_kept)
	);

	// result side: random back-pressure, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_rx) begin
			out_ready <= 1'b0;
			repeat (200) @(negedge clk);
			hold_rx = 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle);
		end
	end

	// watchdog: cycles with no beat on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Timeout: no beat for %0d cycles", STALL_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// offer one pixel beat; entered and left at a falling edge
	task automatic send_pixel(in_t px);
		if ($urandom_range(99) < tx_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
			while ($urandom_range(99) < tx_idle) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= px;
		do @(posedge clk); while (!in_ready);
		pixels_sent++;
		@(negedge clk);
	endtask

	// wait for all results, let the pipe empty, then rewrite every register
	task automatic reconfigure(int thr, int w, int h);
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (12) @(negedge clk);
		cfg_we <= 1'b1; cfg_index <= REG_THRESHOLD; cfg_data <= CFG_BITS'(thr);
		@(negedge clk);
		cfg_index <= REG_WIDTH; cfg_data <= CFG_BITS'(w);
		@(negedge clk);
		cfg_index <= REG_HEIGHT; cfg_data <= CFG_BITS'(h);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic signed [GRAD_BITS-1:0] draw_grad();
		int pick;
		pick = $urandom_range(99);
		if (pick < 10) return '0;
		if (pick < 40) return GRAD_BITS'($urandom_range(16) - 8);
		if (pick < 45) return 16'sh8000;
		return GRAD_BITS'($urandom);
	endfunction

	function automatic in_t draw_pixel();
		in_t px;
		px.magnitude   = ($urandom_range(1)) ? MAG_BITS'($urandom_range(255))
			: MAG_BITS'($urandom);
		px.grad_y      = draw_grad();
		px.grad_x      = draw_grad();
		px.mask_enable = ($urandom_range(9) != 0);
		return px;
	endfunction

	// one whole frame of random pixels at the given register values
	task automatic random_frame(int thr, int w, int h);
		int ew, eh;
		ew = w < 3 ? 3 : (w > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : w);
		eh = h < 3 ? 3 : h;
		reconfigure(thr, w, h);
		for (int k = 0; k < ew * eh; k++) send_pixel(draw_pixel());
		frames_sent++;
	endtask

	function automatic int draw_thr();
		case ($urandom_range(9))
			0: return 0;
			1: return 65535;
			default: return $urandom_range(200);
		endcase
	endfunction

	function automatic int draw_w();
		return ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 24);
	endfunction

	function automatic int draw_h();
		return ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 8);
	endfunction

	initial begin
		logic signed [GRAD_BITS-1:0] dir_gy [25];
		logic signed [GRAD_BITS-1:0] dir_gx [25];
		logic [MAG_BITS-1:0]         dir_mag [25];
		in_t px;

		dir_gy = '{0, 5, -5, 3, -3, 7, -7, 0, 9, 0, -32768, 32767, -32768,
			0, 4, -4, 6, -6, 1, 32767, -1, 2, 0, 8, -8};
		dir_gx = '{0, 3, 3, -5, -5, 7, 7, 9, 0, -9, -32768, -32768, 32767,
			0, 6, 6, -4, -4, 1, 32767, -1, -2, 5, 8, 8};
		dir_mag = '{65535, 0, 100, 200, 65535, 150, 0, 300, 120, 65535,
			80, 65535, 90, 65535, 65534, 40, 65535, 70, 0, 65535,
			1, 500, 65535, 20, 10};

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed frame: 5x5, quadrants, zero gradient, mask off, extremes
		reconfigure(0, 5, 5);
		for (int k = 0; k < 25; k++) begin
			px = '{magnitude: dir_mag[k], grad_y: dir_gy[k], grad_x: dir_gx[k],
				mask_enable: (k % 7 != 3)};
			send_pixel(px);
		end
		frames_sent++;

		// fast sender, slow receiver
		while (pixels_sent < 400) random_frame(draw_thr(), draw_w(), draw_h());

		// slow sender, fast receiver, with one long hold-off to fill the block
		tx_idle = 68; rx_idle = 30;
		reconfigure(10, 20, 8);
		hold_rx = 1'b1;
		for (int k = 0; k < 160; k++) send_pixel(draw_pixel());
		frames_sent++;
		while (pixels_sent < 750) random_frame(draw_thr(), draw_w(), draw_h());

		// full rate on both sides
		tx_idle = 0; rx_idle = 0;
		while (pixels_sent < 1050) random_frame(draw_thr(), draw_w(), draw_h());

		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);

		$display("Covered %0d pixels in %0d frames up to 24 wide and 8 high, small sizes clamped.",
			pixels_sent, frames_sent);
		$display("Checked %0d results, %0d edges kept.", results_seen, edges_kept);
		if (errors == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/cnms_pkg.sv
rtl/cnms_front.sv
rtl/cnms_queue.sv
rtl/cnms_back.sv
rtl/canny_nonmax_suppression_unit.sv
bench/nms_edge_checker.sv
bench/canny_nonmax_suppression_unit_test.sv
